// ===== hw/rtl/ppgc_pkg.sv =====
package ppgc_pkg;

    localparam int MAX_ENTRIES  = 96;
    localparam int MAX_ROWS     = 12;
    localparam int NAME_CHARS   = 63;
    localparam int PREFIX_CHARS = 23;
    localparam int CHUNKS       = (PREFIX_CHARS + 7) / 8;
    localparam int SUM_W        = 39;
    localparam logic [7:0] SLASH = 8'h2F;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_CHAR   = 2'd1,
        CMD_END    = 2'd2,
        CMD_REPORT = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  name_char;
        logic [31:0] entry_size;
    } t_in;

    typedef struct packed {
        logic [3:0]  row_index;
        logic [1:0]  chunk_index;
        logic [63:0] prefix_chunk;
        logic [4:0]  prefix_length;
        logic [6:0]  file_count;
        logic [38:0] byte_total;
        logic        is_total;
        logic        truncated_flag;
        logic        last;
    } t_out;

    // request passed from the front part to the back part
    typedef struct packed {
        logic [1:0]                  kind;
        logic [PREFIX_CHARS*8-1:0]   pfx;
        logic [4:0]                  plen;
        logic [31:0]                 size;
    } t_job;

endpackage

// ===== hw/rtl/ppgc_front.sv =====
module ppgc_front #(
    parameter int NameChars   = ppgc_pkg::NAME_CHARS,
    parameter int PrefixChars = ppgc_pkg::PREFIX_CHARS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  ppgc_pkg::t_in  i_item,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output ppgc_pkg::t_job o_job
);
    localparam int PW = $clog2(NameChars + 1);

    logic [PrefixChars*8-1:0] r_chars;
    logic [4:0]               r_len;
    logic [PW-1:0]            r_pos;
    logic                     r_rooted, r_slash, r_ended;
    logic                     r_jv;
    ppgc_pkg::t_job           r_job;
    logic                     w_acc, w_char;
    logic [PrefixChars*8-1:0] w_pfx;
    logic [4:0]               w_plen;

    assign o_full      = r_jv && !i_job_ready;
    assign w_acc       = i_push && !o_full;
    assign o_job_valid = r_jv;
    assign o_job       = r_job;
    assign w_char      = !r_ended && (r_pos < PW'(NameChars));

    // form the group prefix of the captured name
    always_comb begin
        w_pfx  = '0;
        w_plen = 5'd1;
        if (r_pos == '0) begin
            w_plen = 5'd0;
        end else if (r_rooted && r_slash) begin
            w_plen = r_len;
            for (int k = 0; k < PrefixChars; k++) begin
                if (5'(k) < r_len) w_pfx[k*8 +: 8] = r_chars[k*8 +: 8];
            end
        end else begin
            w_pfx[7:0] = ppgc_pkg::SLASH;
        end
    end

    // capture characters, issue requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jv <= 1'b0; r_pos <= '0; r_len <= '0;
            r_rooted <= 1'b0; r_slash <= 1'b0; r_ended <= 1'b0;
            r_chars <= '0;
        end else begin
            // hold a request until the back takes it, load a new one on accept
            r_jv <= (r_jv && !i_job_ready) ||
                    (w_acc && (ppgc_pkg::t_cmd'(i_item.command) != ppgc_pkg::CMD_CHAR));
            if (w_acc) begin
                case (ppgc_pkg::t_cmd'(i_item.command))
                    ppgc_pkg::CMD_CHAR: begin
                        if (w_char) begin
                            if (i_item.name_char == 8'd0) begin
                                r_ended <= 1'b1;
                            end else begin
                                if (r_pos == '0) begin
                                    r_rooted <= (i_item.name_char == ppgc_pkg::SLASH);
                                end else if (r_rooted && !r_slash &&
                                             i_item.name_char == ppgc_pkg::SLASH) begin
                                    r_slash <= 1'b1;
                                    r_len <= (r_pos >= PW'(PrefixChars)) ?
                                        5'(PrefixChars) : 5'(r_pos + 1'b1);
                                end
                                for (int k = 0; k < PrefixChars; k++) begin
                                    if (r_pos == PW'(k)) r_chars[k*8 +: 8] <= i_item.name_char;
                                end
                                r_pos <= r_pos + 1'b1;
                            end
                        end
                    end
                    ppgc_pkg::CMD_REPORT: begin
                        r_job.kind <= i_item.command;
                    end
                    default: begin
                        // clear and end both drop the capture
                        r_job.kind <= i_item.command;
                        r_job.pfx  <= w_pfx;
                        r_job.plen <= w_plen;
                        r_job.size <= i_item.entry_size;
                        r_pos <= '0; r_len <= '0; r_chars <= '0;
                        r_rooted <= 1'b0; r_slash <= 1'b0; r_ended <= 1'b0;
                    end
                endcase
            end
        end
    end
endmodule

// ===== hw/rtl/ppgc_back.sv =====
module ppgc_back #(
    parameter int MaxEntries  = ppgc_pkg::MAX_ENTRIES,
    parameter int MaxRows     = ppgc_pkg::MAX_ROWS,
    parameter int PrefixChars = ppgc_pkg::PREFIX_CHARS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  ppgc_pkg::t_job i_job,
    output logic           o_empty,
    input  logic           i_pop,
    output ppgc_pkg::t_out o_result
);
    localparam int NG = MaxRows - 1;
    localparam int GW = $clog2(MaxRows);
    localparam int CW = $clog2(MaxEntries + 1);
    localparam int CH = (PrefixChars + 7) / 8;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_UPDATE = 4'b0100,
        S_REPORT = 4'b1000
    } t_state;

    t_state                   r_state;
    ppgc_pkg::t_job           r_job;
    logic [GW-1:0]            r_g, r_used;
    logic [1:0]               r_c;
    logic [CW-1:0]            r_acc;
    logic                     r_ovf;
    logic [38:0]              r_all;
    logic [PrefixChars*8-1:0] m_pfx   [NG];
    logic [4:0]               m_len   [NG];
    logic [6:0]               m_files [NG];
    logic [38:0]              m_bytes [NG];
    logic                     r_ov;
    logic                     n_ov;
    ppgc_pkg::t_out           r_out;
    logic                     w_hit, w_emit;
    logic [PrefixChars*8-1:0] w_data;
    logic [GW-1:0]            w_gi;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_empty     = !r_ov;
    assign o_result    = r_out;
    assign w_emit      = !r_ov || i_pop;
    assign w_gi        = (r_g < GW'(NG)) ? r_g : '0;
    assign w_hit       = (m_len[w_gi] == r_job.plen) && (m_pfx[w_gi] == r_job.pfx);

    // load a new row while reporting, drop the held one on pop
    assign n_ov = (r_state == S_REPORT && w_emit) ? 1'b1 : (i_pop ? 1'b0 : r_ov);

    always_comb begin
        w_data = '0;
        for (int k = 0; k < PrefixChars; k++) begin
            if (5'(k) < m_len[w_gi]) w_data[k*8 +: 8] = m_pfx[w_gi][k*8 +: 8];
        end
    end

    // group search one row a cycle, then update or emit report rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_acc <= '0; r_ovf <= 1'b0;
            r_all <= '0; r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
            case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job; r_g <= '0; r_c <= '0;
                    case (ppgc_pkg::t_cmd'(i_job.kind))
                        ppgc_pkg::CMD_CLEAR: begin
                            r_used <= '0; r_acc <= '0; r_ovf <= 1'b0; r_all <= '0;
                        end
                        ppgc_pkg::CMD_END: begin
                            if (i_job.plen != 5'd0) begin
                                if (r_acc >= CW'(MaxEntries)) r_ovf <= 1'b1;
                                else begin
                                    r_acc <= r_acc + 1'b1;
                                    r_all <= r_all + 39'(i_job.size);
                                    r_state <= S_SEARCH;
                                end
                            end
                        end
                        ppgc_pkg::CMD_REPORT: r_state <= S_REPORT;
                        default: ;
                    endcase
                end
                S_SEARCH: begin
                    if (r_g == r_used) r_state <= S_UPDATE;
                    else if (w_hit) r_state <= S_UPDATE;
                    else r_g <= r_g + 1'b1;
                end
                S_UPDATE: begin
                    r_state <= S_IDLE;
                    if (r_g == r_used) begin
                        if (r_used < GW'(NG)) begin
                            m_pfx[w_gi]   <= r_job.pfx;
                            m_len[w_gi]   <= r_job.plen;
                            m_files[w_gi] <= 7'd1;
                            m_bytes[w_gi] <= 39'(r_job.size);
                            r_used <= r_used + 1'b1;
                        end
                    end else begin
                        m_files[w_gi] <= m_files[w_gi] + 1'b1;
                        m_bytes[w_gi] <= m_bytes[w_gi] + 39'(r_job.size);
                    end
                end
                S_REPORT: if (w_emit) begin
                    r_out.row_index      <= 4'(r_g);
                    r_out.chunk_index    <= r_c;
                    r_out.truncated_flag <= r_ovf;
                    if (r_g == r_used) begin
                        r_out.prefix_chunk  <= '0;
                        r_out.prefix_length <= '0;
                        r_out.file_count    <= 7'(r_acc);
                        r_out.byte_total    <= r_all;
                        r_out.is_total      <= 1'b1;
                        r_out.last          <= (r_c == 2'(CH - 1));
                    end else begin
                        r_out.prefix_chunk  <= 64'(w_data >> (r_c * 64));
                        r_out.prefix_length <= m_len[w_gi];
                        r_out.file_count    <= m_files[w_gi];
                        r_out.byte_total    <= m_bytes[w_gi];
                        r_out.is_total      <= 1'b0;
                        r_out.last          <= 1'b0;
                    end
                    if (r_c == 2'(CH - 1)) begin
                        r_c <= '0;
                        if (r_g == r_used) r_state <= S_IDLE;
                        else r_g <= r_g + 1'b1;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/path_prefix_group_counter_core.sv =====
// Character and clear requests need no table search; an end of entry waits
// on the one-row-a-cycle search of the group table.
// A report emits 3 results per group plus 3 for the total, one per cycle
// while the result side pops. A one-deep request register decouples the
// capture front from the table back. Synchronous active-low reset clears
// counts, flags and capture; group table contents are left as they are.
module path_prefix_group_counter_core #(
    parameter int MaxEntries  = ppgc_pkg::MAX_ENTRIES,
    parameter int MaxRows     = ppgc_pkg::MAX_ROWS,
    parameter int NameChars   = ppgc_pkg::NAME_CHARS,
    parameter int PrefixChars = ppgc_pkg::PREFIX_CHARS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  ppgc_pkg::t_in  i_item,
    output logic           empty,
    input  logic           pop,
    output ppgc_pkg::t_out o_result
);
    logic           w_jv, w_jr;
    ppgc_pkg::t_job w_job;

    ppgc_front #(.NameChars(NameChars), .PrefixChars(PrefixChars)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item,
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    ppgc_back #(.MaxEntries(MaxEntries), .MaxRows(MaxRows),
                .PrefixChars(PrefixChars)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
        .o_empty(empty), .i_pop(pop), .o_result
    );
endmodule

// ===== hw/rtl/ppgc_checker.sv =====
module ppgc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           empty,
    input logic           pop,
    input ppgc_pkg::t_out o_result
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("result changed while stalled");

    // total row carries no prefix
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.is_total |-> o_result.prefix_length == 5'd0)
        else $error("total row with prefix");

    // last only on total row
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.last |-> o_result.is_total)
        else $error("last outside total row");

    // empty after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result after reset");
endmodule

bind path_prefix_group_counter_core ppgc_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop, .o_result
);
